FILE: hw/rtl/gdep_pkg.sv
// ----------------------------------------------------------------------------
// gdep_pkg
// Shared types and constants of the gadget decomposition external product unit.
// ----------------------------------------------------------------------------
package gdep_pkg;

  localparam int unsigned WORD_W = 32;
  // digit_bits is at most 15 when the word is accepted, so a digit fits 15 bits
  localparam int unsigned DIG_W  = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_LWE_DIM    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_CNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_BITS = 2'd2;

  localparam logic OP_WRITE_ENTRY = 1'b0;
  localparam logic OP_CIPHER_WORD = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MAC_RD,
    ST_MAC_MUL,
    ST_MAC_ACC,
    ST_WORD_END,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } gdep_state_e;

  typedef struct packed {
    logic              mul_en;
    logic [DIG_W-1:0]  digit;
    logic [WORD_W-1:0] entry;
    logic [WORD_W-1:0] addend;
  } mac_req_t;

endpackage

FILE: hw/rtl/gdep_mac.sv
// ----------------------------------------------------------------------------
// gdep_mac
// Shared multiply-accumulate unit: registered digit x entry product, then an
// add of that product onto the accumulator value (both modulo 2^32).
// ----------------------------------------------------------------------------
module gdep_mac
  import gdep_pkg::*;
(
  input  logic              clk_i,
  input  mac_req_t          req_i,
  output logic [WORD_W-1:0] sum_o
);

  logic [WORD_W+DIG_W-1:0] prod_full;
  logic [WORD_W-1:0]       prod_q;

  assign prod_full = {{WORD_W{1'b0}}, req_i.digit} * {{DIG_W{1'b0}}, req_i.entry};

  always_ff @(posedge clk_i) begin
    if (req_i.mul_en) begin
      prod_q <= prod_full[WORD_W-1:0];
    end
  end

  assign sum_o = req_i.addend + prod_q;

endmodule

FILE: hw/rtl/gadget_decompose_external_product_unit.sv
// Matrix write beat: accepted straight from idle, no result.
// Ciphertext word: each multiply-accumulate on the shared MAC unit is a matrix
//   read, a multiply and an accumulate, after the row base is reduced.
// Final word: result beats go via the accumulator read port and out register.
// One item at a time; not ready while a word is processed or results drain.
// Reset clears control and accumulator valid bits at once; matrix is undefined.
// ----------------------------------------------------------------------------
// gadget_decompose_external_product_unit
// External product of a stored gadget matrix with an LWE ciphertext, one MAC
// per step under a small sequencer.
// ----------------------------------------------------------------------------
module gadget_decompose_external_product_unit
  import gdep_pkg::*;
#(
  parameter int unsigned MAX_DIMENSION = 63,
  parameter int unsigned MAX_DIGITS    = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 opcode_i,
  input  logic [8:0]           matrix_row_i,
  input  logic [5:0]           matrix_column_i,
  input  logic signed [31:0]   matrix_entry_i,
  input  logic signed [31:0]   cipher_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [5:0]           result_index_o,
  output logic signed [31:0]   result_value_o,
  output logic                 last_o,
  output logic                 status_o
);

  localparam int unsigned MAT_COLS = MAX_DIMENSION + 1;
  localparam int unsigned MAT_ROWS = (MAX_DIMENSION + 1) * MAX_DIGITS;
  localparam int unsigned MAT_DEPTH = MAT_ROWS * MAT_COLS;
  localparam int unsigned AW  = $clog2(MAT_DEPTH);
  localparam int unsigned CW  = $clog2(MAT_COLS);
  localparam int unsigned RCW = ($clog2(MAT_ROWS + 1) > 10) ? $clog2(MAT_ROWS + 1) : 10;

  // configuration
  logic [5:0] lwe_q;
  logic [3:0] cnt_q, bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lwe_q  <= 6'd63;
      cnt_q  <= 4'd8;
      bits_q <= 4'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LWE_DIM:    lwe_q  <= cfg_data_i[5:0];
        CFG_DIGIT_CNT:  cnt_q  <= cfg_data_i[3:0];
        CFG_DIGIT_BITS: bits_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  gdep_state_e       state_q, state_d;
  logic [5:0]        wc_q, wc_d;
  logic [CW-1:0]     n_q, n_d;
  logic [CW-1:0]     col_q, col_d;
  logic [RCW-1:0]    row_q, row_d;
  logic [3:0]        dig_q, dig_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic              out_valid_q, out_valid_d;
  logic [5:0]        out_index_q, out_index_d;
  logic [WORD_W-1:0] out_value_q, out_value_d;
  logic              out_last_q, out_last_d;
  logic              out_status_q, out_status_d;

  logic mat_we, acc_we, acc_clr, mul_en;

  // matrix and accumulator storage
  logic [WORD_W-1:0]   mat_mem [MAT_DEPTH];
  logic [WORD_W-1:0]   mat_rdata_q;
  logic [WORD_W-1:0]   acc_mem [MAT_COLS];
  logic [MAT_COLS-1:0] acc_vld_q;
  logic [WORD_W-1:0]   acc_rdata_q;
  logic                acc_rvld_q;

  logic [31:0]   wr_addr_full;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          wr_ok;

  assign wr_addr_full = {23'd0, matrix_row_i} * MAT_COLS + {26'd0, matrix_column_i};
  assign wr_addr      = wr_addr_full[AW-1:0];
  assign wr_ok        = ({2'd0, matrix_row_i} < 11'(MAT_ROWS)) &&
                        ({1'b0, matrix_column_i} < 7'(MAT_COLS));
  assign rd_addr      = AW'(row_q) * AW'(MAT_COLS) + AW'(col_q);

  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      mat_mem[wr_addr] <= matrix_entry_i;
    end
    mat_rdata_q <= mat_mem[rd_addr];
  end

  logic [WORD_W-1:0] mac_sum;

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[col_q] <= mac_sum;
    end
    acc_rdata_q <= acc_mem[col_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q  <= '0;
      acc_rvld_q <= 1'b0;
    end else begin
      acc_rvld_q <= acc_vld_q[col_q];
      if (acc_clr) begin
        acc_vld_q <= '0;
      end else if (acc_we) begin
        acc_vld_q[col_q] <= 1'b1;
      end
    end
  end

  // shared MAC
  logic [15:0]       top16;
  logic [DIG_W-1:0]  digit;
  mac_req_t          mac_req;

  assign top16 = word_q[31:16] >> (5'd16 - {1'b0, bits_q});
  assign digit = top16[DIG_W-1:0];

  assign mac_req.mul_en = mul_en;
  assign mac_req.digit  = digit;
  assign mac_req.entry  = mat_rdata_q;
  assign mac_req.addend = acc_rvld_q ? acc_rdata_q : '0;

  gdep_mac u_mac (
    .clk_i (clk_i),
    .req_i (mac_req),
    .sum_o (mac_sum)
  );

  // sequencer
  logic [7:0]  prod_bits;
  logic [9:0]  row_base;
  logic [5:0]  n_eff;
  logic [31:0] offset;

  assign prod_bits = {4'd0, bits_q} * {4'd0, cnt_q};
  assign row_base  = {4'd0, wc_q} * {6'd0, cnt_q};
  assign n_eff     = (lwe_q > 6'(MAX_DIMENSION)) ? 6'(MAX_DIMENSION) : lwe_q;
  assign offset    = 32'd1 << (5'd31 - prod_bits[4:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wc_q        <= wc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q          <= n_d;
    col_q        <= col_d;
    row_q        <= row_d;
    dig_q        <= dig_d;
    word_q       <= word_d;
    out_index_q  <= out_index_d;
    out_value_q  <= out_value_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  always_comb begin
    state_d      = state_q;
    wc_d         = wc_q;
    n_d          = n_q;
    col_d        = col_q;
    row_d        = row_q;
    dig_d        = dig_q;
    word_d       = word_q;
    out_valid_d  = out_valid_q;
    out_index_d  = out_index_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    mat_we       = 1'b0;
    acc_we       = 1'b0;
    acc_clr      = 1'b0;
    mul_en       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == OP_WRITE_ENTRY) begin
            mat_we = wr_ok;
          end else if (prod_bits > 8'd31) begin
            // rejected word: single error beat, state untouched
            out_index_d  = wc_q;
            out_value_d  = '0;
            out_last_d   = 1'b1;
            out_status_d = STATUS_ERR;
            out_valid_d  = 1'b1;
            state_d      = ST_EMIT_WAIT;
          end else begin
            word_d  = cipher_word_i + offset;
            n_d     = CW'(n_eff);
            row_d   = RCW'(row_base);
            col_d   = '0;
            dig_d   = '0;
            state_d = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        // row base modulo matrix rows, one subtract per cycle
        if (row_q >= RCW'(MAT_ROWS)) begin
          row_d = row_q - RCW'(MAT_ROWS);
        end else if (bits_q == 4'd0 || cnt_q == 4'd0) begin
          state_d = ST_WORD_END;
        end else begin
          state_d = ST_MAC_RD;
        end
      end
      ST_MAC_RD: begin
        state_d = ST_MAC_MUL;
      end
      ST_MAC_MUL: begin
        mul_en  = 1'b1;
        state_d = ST_MAC_ACC;
      end
      ST_MAC_ACC: begin
        acc_we = 1'b1;
        if (col_q == n_q) begin
          col_d  = '0;
          word_d = word_q << bits_q;
          row_d  = (row_q == RCW'(MAT_ROWS - 1)) ? '0 : row_q + 1'b1;
          dig_d  = dig_q + 4'd1;
          state_d = (dig_q == cnt_q - 4'd1) ? ST_WORD_END : ST_MAC_RD;
        end else begin
          col_d   = col_q + 1'b1;
          state_d = ST_MAC_RD;
        end
      end
      ST_WORD_END: begin
        if (wc_q >= 6'(n_q)) begin
          col_d   = '0;
          state_d = ST_EMIT_RD;
        end else begin
          wc_d    = wc_q + 6'd1;
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        out_index_d  = 6'(col_q);
        out_value_d  = acc_rvld_q ? acc_rdata_q : '0;
        out_last_d   = (col_q == n_q);
        out_status_d = STATUS_OK;
        out_valid_d  = 1'b1;
        state_d      = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (out_status_q == STATUS_ERR) begin
            state_d = ST_IDLE;
          end else if (out_last_q) begin
            acc_clr = 1'b1;
            wc_d    = '0;
            state_d = ST_IDLE;
          end else begin
            col_d   = col_q + 1'b1;
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_index_o = out_index_q;
  assign result_value_o = out_value_q;
  assign last_o         = out_last_q;
  assign status_o       = out_status_q;

endmodule

FILE: hw/rtl/gdep_checker.sv
// ----------------------------------------------------------------------------
// gdep_checker
// Port-level checks of the gadget decomposition external product unit.
// ----------------------------------------------------------------------------
module gdep_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [5:0]         result_index_o,
  input logic signed [31:0] result_value_o,
  input logic               last_o,
  input logic               status_o
);

  // no new beat is taken while a result beat is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while result beat pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o) &&
    $stable(result_index_o) && $stable(last_o) && $stable(status_o))
    else $error("stalled result beat changed");

  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> last_o && (result_value_o == 32'sd0))
    else $error("error beat not last or nonzero");

  // after a non-last beat the stream continues; input stays blocked
  a_stream_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> !in_ready_o)
    else $error("input reopened mid result stream");

endmodule

bind gadget_decompose_external_product_unit gdep_checker u_gdep_checker (.*);

FILE: sim/gdep_tb_pkg.sv
// ----------------------------------------------------------------------------
// gdep_tb_pkg
// Expected-result tracking for the external product unit testbench: a copy of
// the gadget matrix, the accumulators and the registers, updated per beat.
// ----------------------------------------------------------------------------
package gdep_tb_pkg;
  import gdep_pkg::*;

  localparam int unsigned DIM_MAX    = 63;
  localparam int unsigned DIGITS_MAX = 8;
  localparam int unsigned MAT_COLS   = DIM_MAX + 1;
  localparam int unsigned MAT_ROWS   = MAT_COLS * DIGITS_MAX;

  typedef struct packed {
    logic [5:0]  idx;
    logic [31:0] sum;
    logic        last;
    logic        status;
  } product_beat_t;

  class ext_product_sb;
    logic [31:0]   gadget_mem [MAT_ROWS][MAT_COLS];
    logic [31:0]   acc_sum [MAT_COLS];
    logic [5:0]    word_cnt;
    logic [5:0]    dim;
    logic [3:0]    cnt;
    logic [3:0]    bits;
    product_beat_t expected_beats [$];
    int unsigned   fail_count;

    function new();
      word_cnt   = '0;
      dim        = 6'd63;
      cnt        = 4'd8;
      bits       = 4'd2;
      fail_count = 0;
      foreach (acc_sum[c]) acc_sum[c] = '0;
    endfunction

    task report_mismatch(string what);
      if (fail_count < 50) $display("MISMATCH: %s", what);
      fail_count++;
    endtask

    task set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] data);
      case (index)
        CFG_LWE_DIM:    dim  = data;
        CFG_DIGIT_CNT:  cnt  = data[3:0];
        CFG_DIGIT_BITS: bits = data[3:0];
        default: ;
      endcase
    endtask

    // one accepted input beat
    task take_item(logic op, logic [8:0] row, logic [5:0] col, logic [31:0] entry,
                   logic [31:0] word);
      if (op == OP_WRITE_ENTRY) begin
        gadget_mem[row][col] = entry;
      end else begin
        absorb_word(word);
      end
    endtask

    task absorb_word(logic [31:0] word);
      int          p;
      int          n;
      int          b;
      int          dc;
      int          mrow;
      logic [31:0] w;
      logic [31:0] mask;
      logic [31:0] digit;
      b  = int'(bits);
      dc = int'(cnt);
      n  = int'(dim);
      p  = b * dc;
      // too many digit bits: reject, report the current word position
      if (p > 31) begin
        expected_beats.push_back('{word_cnt, 32'd0, 1'b1, STATUS_ERR});
        return;
      end
      w    = word + (32'd1 << (31 - p));
      mask = (32'd1 << b) - 32'd1;
      if (b != 0) begin
        for (int i = 0; i < dc; i++) begin
          digit = (w >> (32 - (i + 1) * b)) & mask;
          mrow  = (int'(word_cnt) * dc + i) % MAT_ROWS;
          for (int c = 0; c <= n; c++) acc_sum[c] += digit * gadget_mem[mrow][c];
        end
      end
      // counter at or past n (n may have been lowered) closes the ciphertext
      if (int'(word_cnt) >= n) begin
        for (int k = 0; k <= n; k++) begin
          expected_beats.push_back('{6'(k), acc_sum[k], (k == n), STATUS_OK});
        end
        foreach (acc_sum[c]) acc_sum[c] = '0;
        word_cnt = '0;
      end else begin
        word_cnt = word_cnt + 6'd1;
      end
    endtask

    task check_beat(logic [5:0] idx, logic [31:0] sum, logic last, logic status);
      product_beat_t want;
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat idx=%0d sum=%h last=%b status=%b",
                                  idx, sum, last, status));
        return;
      end
      want = expected_beats.pop_front();
      if (idx !== want.idx)
        report_mismatch($sformatf("result_index %0d, want %0d", idx, want.idx));
      if (sum !== want.sum)
        report_mismatch($sformatf("result_value %h, want %h (idx %0d)", sum, want.sum,
                                  want.idx));
      if (last !== want.last)
        report_mismatch($sformatf("last %b, want %b (idx %0d)", last, want.last, want.idx));
      if (status !== want.status)
        report_mismatch($sformatf("status %b, want %b (idx %0d)", status, want.status,
                                  want.idx));
    endtask

    task check_leftover();
      if (expected_beats.size() != 0)
        report_mismatch($sformatf("%0d expected beats never arrived",
                                  expected_beats.size()));
    endtask
  endclass

endpackage

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives matrix writes and ciphertext words into the external product unit
// under several register settings and idle patterns, and checks every result
// beat against a running prediction of the accumulated sums.
// ----------------------------------------------------------------------------
module tb_top;
  import gdep_pkg::*;
  import gdep_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  localparam int unsigned LONG_HOLD = 4000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 opcode_i;
  logic [8:0]           matrix_row_i;
  logic [5:0]           matrix_column_i;
  logic signed [31:0]   matrix_entry_i;
  logic signed [31:0]   cipher_word_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [5:0]           result_index_o;
  logic signed [31:0]   result_value_o;
  logic                 last_o;
  logic                 status_o;

  ext_product_sb sb;
  idle_mode_e    idle_mode = IDLE_NONE;
  int unsigned   hold_requests = 0;
  bit            entry_loaded [MAT_ROWS][MAT_COLS];

  gadget_decompose_external_product_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .matrix_row_i    (matrix_row_i),
    .matrix_column_i (matrix_column_i),
    .matrix_entry_i  (matrix_entry_i),
    .cipher_word_i   (cipher_word_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_index_o  (result_index_o),
    .result_value_o  (result_value_o),
    .last_o          (last_o),
    .status_o        (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned stall_pct(bit sender_side);
    case (idle_mode)
      IDLE_SEND: return sender_side ? 71 : 0;
      IDLE_RECV: return sender_side ? 0 : 71;
      IDLE_BOTH: return 23;
      default:   return 0;
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // entered right after a falling edge, returns right after one
  task automatic send_beat(logic op, logic [8:0] row, logic [5:0] col, logic [31:0] entry,
                           logic [31:0] word);
    while ($urandom_range(99) < stall_pct(1'b1)) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    opcode_i        = op;
    matrix_row_i    = row;
    matrix_column_i = col;
    matrix_entry_i  = entry;
    cipher_word_i   = word;
    in_valid_i      = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_item(op, row, col, entry, word);
    @(negedge clk_i);
  endtask

  task automatic send_write(logic [8:0] row, logic [5:0] col, logic [31:0] entry);
    send_beat(OP_WRITE_ENTRY, row, col, entry, $urandom());
    entry_loaded[row][col] = 1'b1;
  endtask

  // every matrix entry the next word touches must hold a written value
  task automatic load_needed_entries();
    int p;
    int mrow;
    p = int'(sb.bits) * int'(sb.cnt);
    if (sb.bits == 0 || p > 31) return;
    for (int i = 0; i < int'(sb.cnt); i++) begin
      mrow = (int'(sb.word_cnt) * int'(sb.cnt) + i) % MAT_ROWS;
      for (int c = 0; c <= int'(sb.dim); c++) begin
        if (!entry_loaded[mrow][c]) send_write(9'(mrow), 6'(c), pick_word());
      end
    end
  endtask

  task automatic send_cipher(logic [31:0] word);
    load_needed_entries();
    send_beat(OP_CIPHER_WORD, 9'($urandom_range(511)), 6'($urandom_range(63)), $urandom(),
              word);
  endtask

  task automatic wait_for_results();
    in_valid_i = 1'b0;
    while (sb.expected_beats.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DAT_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = index;
    cfg_data_i  = data;
    @(posedge clk_i);
    sb.set_register(index, data);
    @(negedge clk_i);
  endtask

  // registers change only with the unit idle; a non-final word gives no
  // result, so leave room for its MAC pass after the last beat drained
  task automatic set_config(int unsigned dim, int unsigned cnt, int unsigned bits);
    wait_for_results();
    repeat (4 * (int'(sb.cnt) + 1) * (int'(sb.dim) + 2) + 16) @(negedge clk_i);
    write_register(CFG_LWE_DIM, 6'(dim));
    write_register(CFG_DIGIT_CNT, {2'($urandom_range(3)), 4'(cnt)});
    write_register(CFG_DIGIT_BITS, {2'($urandom_range(3)), 4'(bits)});
    cfg_we_i = 1'b0;
  endtask

  task automatic run_phase(int unsigned dim, int unsigned cnt, int unsigned bits,
                           idle_mode_e mode, int unsigned words, bit long_hold);
    set_config(dim, cnt, bits);
    idle_mode = mode;
    if (long_hold) hold_requests++;
    for (int k = 0; k < int'(words); k++) begin
      if ($urandom_range(99) < 12) begin
        send_write(9'($urandom_range(511)), 6'($urandom_range(63)), pick_word());
      end else begin
        send_cipher(pick_word());
      end
      if ($urandom_range(99) < 2) wait_for_results();
    end
  endtask

  initial begin : stimulus
    sb              = new();
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = CFG_LWE_DIM;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    opcode_i        = OP_WRITE_ENTRY;
    matrix_row_i    = '0;
    matrix_column_i = '0;
    matrix_entry_i  = '0;
    cipher_word_i   = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes and the corner cases
    set_config(1, 2, 4);
    send_write(9'd0, 6'd0, 32'h7FFF_FFFF);
    send_write(9'd0, 6'd1, 32'h8000_0000);
    send_write(9'd1, 6'd0, 32'hFFFF_FFFF);
    send_write(9'd1, 6'd1, 32'h0000_0000);
    send_write(9'd511, 6'd63, $urandom());
    send_cipher(32'h7FFF_FFFF);
    send_cipher(32'h8000_0000);
    set_config(3, 2, 4);
    send_cipher(32'hFFFF_FFFF);
    send_cipher(32'h0000_0000);
    // digit bits times count past 31, mid-ciphertext
    set_config(3, 8, 4);
    send_cipher($urandom());
    set_config(3, 15, 15);
    send_cipher($urandom());
    // zero digit bits still advances the word position
    set_config(3, 2, 0);
    send_cipher($urandom());
    // n lowered below the word position: next word closes the ciphertext
    set_config(1, 2, 4);
    send_cipher($urandom());
    // zero digits
    set_config(2, 0, 4);
    repeat (3) send_cipher($urandom());
    // widest accepted split, offset of 2
    set_config(4, 15, 2);
    repeat (2) send_cipher($urandom());
    set_config(0, 1, 1);
    send_cipher(32'h8000_0000);

    run_phase(2, 3, 5, IDLE_NONE, 60, 1'b0);
    run_phase(0, 4, 7, IDLE_SEND, 50, 1'b0);
    run_phase(5, 2, 8, IDLE_RECV, 60, 1'b1);
    run_phase(7, 8, 3, IDLE_BOTH, 50, 1'b0);
    run_phase(63, 1, 8, IDLE_SEND, 70, 1'b0);
    // digit rows wrap past the end of the matrix
    run_phase(35, 15, 2, IDLE_NONE, 60, 1'b0);
    for (int ph = 0; ph < 5; ph++) begin
      run_phase($urandom_range(12), $urandom_range(15),
                $urandom_range(1) ? $urandom_range(15) : $urandom_range(3),
                idle_mode_e'(ph % 4), 30, 1'b0);
    end

    in_valid_i = 1'b0;
    for (int k = 0; k < 400000 && sb.expected_beats.size() != 0; k++) @(negedge clk_i);
    repeat (4000) @(negedge clk_i);
    sb.check_leftover();
    if (sb.fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left   = 0;
    hold_seen   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = ($urandom_range(99) >= stall_pct(1'b0));
      end
    end
  end

  always @(posedge clk_i) begin : beat_monitor
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_beat(result_index_o, result_value_o, last_o, status_o);
  end

  initial begin : watchdog
    #200ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
